// File: rtl/orrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orrl_pkg
// Shared constants and types for the record ring log.
// ----------------------------------------------------------------------------
package orrl_pkg;

	localparam logic [15:0] SKIP_LENGTH = 16'hFFFF;
	localparam logic [7:0]  FILL_BYTE   = 8'hFF;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// request as held in the front queue
	typedef struct packed {
		logic        op;
		logic [7:0]  facility;
		logic [7:0]  level;
		logic [15:0] message_length;
		logic [63:0] timestamp;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [11:0] entry_offset;
		logic [11:0] tail_offset;
		logic [8:0]  evicted_count;
		logic        wrapped;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAPCHK,
		ST_TRD0,
		ST_TRD1,
		ST_TADV,
		ST_FILL,
		ST_EVCHK,
		ST_HDR,
		ST_DONE
	} state_t;

endpackage

// File: rtl/orrl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orrl_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface orrl_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/overwriting_record_ring_log_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_record_ring_log_core
// Variable-length record ring log that overwrites the oldest records.
// ----------------------------------------------------------------------------
// message byte requests: one per cycle through the two-entry queue while idle
// begin requests: wrap check, per evicted record a read of the length bytes
//   and a tail advance, fill of the ring end when the head wraps, then header
//   writes, held at the last byte until the previous result is taken
// result: registered at the same edge as the last header byte write
// reset: asynchronous, clears head, tail, cursor and queue; ring contents stay
module overwriting_record_ring_log_core #(
	parameter int RING_BYTES        = 4096,
	parameter int MAX_MESSAGE_BYTES = 1024,
	parameter int HEADER_BYTES      = 16,
	parameter int ALIGN_BYTES       = 8
) (
	input logic clk,
	input logic arst_n,
	orrl_if.sink   in_ch,
	orrl_if.source out_ch
);
	logic           q_valid, q_pop;
	orrl_pkg::req_t q_req;

	// request queue
	orrl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.data),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	// ring sequencer
	orrl_back #(
		.RING_BYTES(RING_BYTES), .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
		.HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
	);
endmodule

// File: rtl/orrl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orrl_front
// Two-entry request queue between input port and back end.
// ----------------------------------------------------------------------------
module orrl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  orrl_pkg::req_t  in_req,
	output logic            q_valid,
	input  logic            q_pop,
	output orrl_pkg::req_t  q_req
);
	orrl_pkg::req_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_req;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_pop && q_valid};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
endmodule

// File: rtl/orrl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orrl_back
// Ring sequencer: wrap fill, tail eviction walk, header and byte writes.
// ----------------------------------------------------------------------------
module orrl_back #(
	parameter int RING_BYTES        = 4096,
	parameter int MAX_MESSAGE_BYTES = 1024,
	parameter int HEADER_BYTES      = 16,
	parameter int ALIGN_BYTES       = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  orrl_pkg::req_t q_req,
	output logic           res_valid,
	input  logic           res_ready,
	output orrl_pkg::res_t res
);
	localparam int AW = $clog2(RING_BYTES);
	localparam int PW = AW + 1;
	localparam int HW = $clog2(HEADER_BYTES);

	orrl_pkg::state_t st_q, st_d;
	logic [7:0]    ring [RING_BYTES];
	logic [PW-1:0] head_q, tail_q, cur_q, fill_q;
	logic [11:0]   rem_q;
	logic [15:0]   ml_q, rl_q;
	logic [7:0]    fac_q, lvl_q;
	logic [63:0]   ts_q;
	logic [8:0]    ev_q;
	logic          wr_q, wrapev_q;
	logic [HW-1:0] hi_q;
	logic [PW:0]   guard_q;
	logic [7:0]    rd_q, lo_q;
	logic [PW-1:0] tail_rd_d;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	orrl_pkg::res_t res_q;
	logic          resv_q;

	// length truncation and alignment
	logic [15:0] ml_c, rl_c;
	always_comb begin
		ml_c = (q_req.message_length > 16'(MAX_MESSAGE_BYTES)) ?
			16'(MAX_MESSAGE_BYTES) : q_req.message_length;
		rl_c = 16'(((32'(HEADER_BYTES) + 32'(ml_c) + 32'(ALIGN_BYTES) - 32'd1)
			/ ALIGN_BYTES) * ALIGN_BYTES);
	end

	// header byte select
	logic [7:0] hb;
	always_comb begin
		case (hi_q)
			HW'(0): hb = rl_q[7:0];
			HW'(1): hb = rl_q[15:8];
			HW'(2): hb = ml_q[7:0];
			HW'(3): hb = ml_q[15:8];
			HW'(4): hb = fac_q;
			HW'(5): hb = lvl_q;
			default: hb = (32'(hi_q) >= 8 && 32'(hi_q) < 16) ?
				ts_q[8*(32'(hi_q)-8) +: 8] : 8'h00;
		endcase
	end

	// stored record length at the tail and next tail
	logic [15:0]   tlen;
	logic [PW+16:0] tnext;
	always_comb begin
		tlen  = {rd_q, lo_q};
		tnext = (PW+17)'(tail_q) + (PW+17)'(tlen);
		if (tlen == 16'd0 || tlen == orrl_pkg::SKIP_LENGTH ||
		    tnext + (PW+17)'(HEADER_BYTES) > (PW+17)'(RING_BYTES))
			tail_rd_d = '0;
		else
			tail_rd_d = tnext[PW-1:0];
	end

	// the walk starts only with the head below the tail, then runs while they differ and the record overlaps the tail
	logic byte_item, fits, ev_more, hdr_last, res_free;
	logic [PW+16:0] hsum;
	always_comb begin
		byte_item = q_valid && q_req.op == orrl_pkg::OP_BYTE;
		hsum      = (PW+17)'(head_q) + (PW+17)'(rl_q);
		fits      = hsum <= (PW+17)'(RING_BYTES);
		ev_more   = (guard_q == '0 ? head_q < tail_q : head_q != tail_q) &&
			hsum > (PW+17)'(tail_q) && guard_q <= (PW+1)'(RING_BYTES);
		hdr_last  = 32'(hi_q) == HEADER_BYTES - 1;
		res_free  = !resv_q || res_ready;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			orrl_pkg::ST_IDLE:
				if (q_valid && q_req.op == orrl_pkg::OP_BEGIN) st_d = orrl_pkg::ST_WRAPCHK;
			orrl_pkg::ST_WRAPCHK:
				if (fits) st_d = orrl_pkg::ST_EVCHK;
				else if (tail_q == '0 && tail_q != head_q) st_d = orrl_pkg::ST_TRD0;
				else st_d = orrl_pkg::ST_FILL;
			orrl_pkg::ST_TRD0: st_d = orrl_pkg::ST_TRD1;
			orrl_pkg::ST_TRD1: st_d = orrl_pkg::ST_TADV;
			orrl_pkg::ST_TADV: st_d = wrapev_q ? orrl_pkg::ST_FILL : orrl_pkg::ST_EVCHK;
			orrl_pkg::ST_FILL:
				if (fill_q >= PW'(RING_BYTES - 1)) st_d = orrl_pkg::ST_EVCHK;
			orrl_pkg::ST_EVCHK:
				st_d = ev_more ? orrl_pkg::ST_TRD0 : orrl_pkg::ST_HDR;
			orrl_pkg::ST_HDR: if (hdr_last && res_free) st_d = orrl_pkg::ST_DONE;
			orrl_pkg::ST_DONE: st_d = orrl_pkg::ST_IDLE;
			default: st_d = orrl_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		rd_addr = tail_q;
		case (st_q)
			orrl_pkg::ST_IDLE: q_pop = byte_item;
			orrl_pkg::ST_TRD0: rd_en = 1'b1;
			orrl_pkg::ST_TRD1: begin rd_en = 1'b1; rd_addr = tail_q + PW'(1); end
			orrl_pkg::ST_DONE: q_pop = 1'b1;
			default: ;
		endcase
	end

	// ring memory port
	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= ring[rd_addr[AW-1:0]];
		if (st_q == orrl_pkg::ST_TRD1) lo_q <= rd_q;
		if (st_q == orrl_pkg::ST_FILL && fill_q < PW'(RING_BYTES))
			ring[fill_q[AW-1:0]] <= orrl_pkg::FILL_BYTE;
		else if (st_q == orrl_pkg::ST_HDR &&
			(PW+1)'(head_q) + (PW+1)'(hi_q) < (PW+1)'(RING_BYTES))
			ring[AW'(head_q + PW'(hi_q))] <= hb;
		else if (st_q == orrl_pkg::ST_IDLE && byte_item && rem_q != '0 &&
			cur_q < PW'(RING_BYTES))
			ring[cur_q[AW-1:0]] <= q_req.data_byte;
	end

	// begin payload capture
	always_ff @(posedge clk) begin
		if (st_q == orrl_pkg::ST_IDLE && st_d == orrl_pkg::ST_WRAPCHK) begin
			ml_q <= ml_c; rl_q <= rl_c;
			fac_q <= q_req.facility; lvl_q <= q_req.level; ts_q <= q_req.timestamp;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= orrl_pkg::ST_IDLE;
			head_q <= '0; tail_q <= '0; cur_q <= '0; rem_q <= '0;
			fill_q <= '0; ev_q <= '0; wr_q <= 1'b0; wrapev_q <= 1'b0;
			hi_q <= '0; guard_q <= '0; resv_q <= 1'b0; res_q <= '0;
		end else begin
			st_q <= st_d;
			// result register: drains on accept, loads after the last header byte
			resv_q <= (resv_q && !res_ready) ||
				(st_q == orrl_pkg::ST_HDR && hdr_last && res_free);
			case (st_q)
				orrl_pkg::ST_IDLE: begin
					if (byte_item && rem_q != '0) begin
						cur_q <= cur_q + PW'(1); rem_q <= rem_q - 12'd1;
					end
					ev_q <= '0; wr_q <= 1'b0; guard_q <= '0; hi_q <= '0;
				end
				orrl_pkg::ST_WRAPCHK: begin
					fill_q <= head_q;
					wrapev_q <= !fits;
				end
				orrl_pkg::ST_TADV: begin
					tail_q <= tail_rd_d;
					if (ev_q != 9'd511) ev_q <= ev_q + 9'd1;
					if (!wrapev_q) guard_q <= guard_q + (PW+1)'(1);
					wrapev_q <= 1'b0;
				end
				orrl_pkg::ST_FILL: begin
					fill_q <= fill_q + PW'(1);
					if (st_d == orrl_pkg::ST_EVCHK) begin
						head_q <= '0; wr_q <= 1'b1; wrapev_q <= 1'b0;
					end
				end
				orrl_pkg::ST_HDR: begin
					if (!hdr_last) hi_q <= hi_q + HW'(1);
					if (hdr_last && res_free) begin
						res_q.entry_offset <= 12'(head_q);
						res_q.tail_offset <= 12'(tail_q);
						res_q.evicted_count <= ev_q;
						res_q.wrapped <= wr_q;
						cur_q <= head_q + PW'(HEADER_BYTES);
						rem_q <= ml_q[11:0];
						head_q <= fits ? hsum[PW-1:0] : PW'(RING_BYTES);
					end
				end
				default: ;
			endcase
		end
	end

	assign res_valid = resv_q;
	assign res       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == orrl_pkg::ST_IDLE || st_q == orrl_pkg::ST_DONE))
		else $error("pop outside idle/done");
	assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PW'(RING_BYTES)) else $error("head past ring end");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == orrl_pkg::ST_FILL && st_d == orrl_pkg::ST_EVCHK) |=> head_q == '0)
		else $error("head not wrapped after fill");
endmodule

// File: tb/sv/overwriting_record_ring_log_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_record_ring_log_core_tb
// Self-checking bench for the record ring log. A directed table covers
// length extremes, truncation, the first wrap with eviction, ignored extra
// bytes and abandoned records. A random stream of mostly well-formed records
// follows, under several sender and receiver idling patterns and one long
// receiver hold-off. Every result is checked against a pinned table value or an in-bench ring model.
// ----------------------------------------------------------------------------
module overwriting_record_ring_log_core_tb;

	localparam int RING   = 4096;
	localparam int MAXMSG = 1024;
	localparam int HDR    = 16;
	localparam int ALIGN  = 8;

	logic clk;
	logic arst_n;

	orrl_if #(.T(orrl_pkg::req_t)) in_ch ();
	orrl_if #(.T(orrl_pkg::res_t)) out_ch ();

	overwriting_record_ring_log_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// ring model state
	logic [7:0] ring_mem [RING];
	int         head_pos;
	int         tail_pos;
	int         cursor_pos;
	int         bytes_left;

	orrl_pkg::res_t pending_results [$];
	int         mismatches;
	int         begins_sent;
	int         bytes_sent;
	int         results_seen;
	int         wraps_seen;
	int         max_evicted;

	// typed expectation for the request on the wire, if any
	bit             pin_valid;
	orrl_pkg::res_t pin_res;

	// idling control
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_request;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// move the tail past one stored record
	function automatic int step_tail();
		int len;
		int nxt;
		if (tail_pos == head_pos)
			return 0;
		len = {ring_mem[tail_pos + 1], ring_mem[tail_pos]};
		nxt = tail_pos + len;
		if (len == 0 || len == orrl_pkg::SKIP_LENGTH || nxt + HDR > RING)
			nxt = 0;
		tail_pos = nxt;
		return 1;
	endfunction

	// compute the result of one request and update the ring copy
	function automatic bit predict_record(input orrl_pkg::req_t r,
		output orrl_pkg::res_t o);
		int msg;
		int rec;
		int ev;
		int guard;
		logic [7:0] hb [HDR];
		ev    = 0;
		guard = 0;
		o     = '0;
		if (r.op == orrl_pkg::OP_BYTE) begin
			if (bytes_left > 0) begin
				if (cursor_pos < RING)
					ring_mem[cursor_pos] = r.data_byte;
				cursor_pos++;
				bytes_left--;
			end
			return 1'b0;
		end
		msg = (r.message_length > MAXMSG) ? MAXMSG : r.message_length;
		rec = ((HDR + msg + ALIGN - 1) / ALIGN) * ALIGN;
		if (head_pos + rec > RING) begin
			if (tail_pos == 0)
				ev += step_tail();
			for (int i = head_pos; i < RING; i++)
				ring_mem[i] = orrl_pkg::FILL_BYTE;
			head_pos  = 0;
			o.wrapped = 1'b1;
		end
		if (head_pos < tail_pos) begin
			while (head_pos != tail_pos && head_pos + rec > tail_pos && guard <= RING) begin
				ev += step_tail();
				guard++;
			end
		end
		for (int i = 0; i < HDR; i++)
			hb[i] = 8'h00;
		hb[0] = rec[7:0];
		hb[1] = rec[15:8];
		hb[2] = msg[7:0];
		hb[3] = msg[15:8];
		hb[4] = r.facility;
		hb[5] = r.level;
		for (int i = 0; i < 8 && 8 + i < HDR; i++)
			hb[8 + i] = r.timestamp[8 * i +: 8];
		for (int i = 0; i < HDR; i++)
			if (head_pos + i < RING)
				ring_mem[head_pos + i] = hb[i];
		o.entry_offset = head_pos[11:0];
		cursor_pos     = head_pos + HDR;
		bytes_left     = msg;
		head_pos       = head_pos + rec;
		if (head_pos > RING)
			head_pos = RING;
		o.tail_offset   = tail_pos[11:0];
		o.evicted_count = (ev > 511) ? 9'd511 : ev[8:0];
		return 1'b1;
	endfunction

	// accept requests and check results at the rising edge
	always @(posedge clk) begin
		orrl_pkg::res_t got;
		orrl_pkg::res_t want;
		orrl_pkg::res_t calc;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (predict_record(in_ch.data, calc))
				pending_results.push_back(pin_valid ? pin_res : calc);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			results_seen++;
			if (got.wrapped)
				wraps_seen++;
			if (got.evicted_count > max_evicted)
				max_evicted = got.evicted_count;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t: %p", $realtime, got);
			end else begin
				want = pending_results.pop_front();
				if (got.entry_offset != want.entry_offset ||
				    got.tail_offset != want.tail_offset ||
				    got.evicted_count != want.evicted_count ||
				    got.wrapped != want.wrapped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: expected %p, got %p",
							$realtime, want, got);
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		int hold_cycles;
		out_ch.ready = 1'b0;
		hold_cycles  = 0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_cycles == 0)
				hold_cycles = 3000;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready = 1'b0;
				if (hold_cycles == 0)
					hold_request = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// present one request and wait until it is taken
	task automatic send_request(input orrl_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.data  = r;
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
		if (r.op == orrl_pkg::OP_BEGIN)
			begins_sent++;
		else
			bytes_sent++;
	endtask

	function automatic orrl_pkg::req_t rand_request(input logic op);
		orrl_pkg::req_t r;
		r.op             = op;
		r.facility       = 8'($urandom);
		r.level          = 8'($urandom);
		r.message_length = 16'($urandom);
		r.timestamp      = {$urandom, $urandom};
		r.data_byte      = 8'($urandom);
		return r;
	endfunction

	// one record: begin then a message, mostly the right number of bytes
	task automatic send_record();
		orrl_pkg::req_t r;
		int   n;
		int   msg;
		r = rand_request(orrl_pkg::OP_BEGIN);
		case ($urandom_range(19))
			0:       r.message_length = 16'($urandom_range(65535));
			1:       r.message_length = 16'($urandom_range(1024, 900));
			2, 3:    r.message_length = 16'($urandom_range(400));
			default: r.message_length = 16'($urandom_range(40));
		endcase
		pin_valid = 1'b0;
		send_request(r);
		msg = (r.message_length > MAXMSG) ? MAXMSG : r.message_length;
		if (msg > 48)
			msg = $urandom_range(48);
		case ($urandom_range(9))
			0:       n = (msg > 0) ? $urandom_range(msg - 1) : 0;
			1:       n = msg + $urandom_range(1, 3);
			default: n = msg;
		endcase
		for (int i = 0; i < n; i++)
			send_request(rand_request(orrl_pkg::OP_BYTE));
	endtask

	task automatic drain(input int extra);
		int waited;
		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (extra) @(negedge clk);
	endtask

	typedef struct {
		orrl_pkg::req_t r;
		bit             pinned;
		orrl_pkg::res_t want;
	} stim_row_t;

	// directed table
	stim_row_t script [$];

	initial begin
		stim_row_t row;
		int        budget;
		mismatches     = 0;
		begins_sent    = 0;
		bytes_sent     = 0;
		results_seen   = 0;
		wraps_seen     = 0;
		max_evicted    = 0;
		head_pos       = 0;
		tail_pos       = 0;
		cursor_pos     = 0;
		bytes_left     = 0;
		pin_valid      = 1'b0;
		pin_res        = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.data     = '0;
		arst_n         = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message right after reset
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h00, 8'h00, 16'd0, 64'd0, 8'h00}, 1'b1,
			'{12'd0, 12'd0, 9'd0, 1'b0}});
		// byte with nothing remaining is ignored
		script.push_back('{'{orrl_pkg::OP_BYTE, 8'h00, 8'h00, 16'd0, 64'd0, 8'hFF}, 1'b0,
			'0});
		// maximum length field is cut, all-ones header
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'hFF, 8'hFF, 16'hFFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 8'h00}, 1'b1, '{12'd16, 12'd0, 9'd0, 1'b0}});
		script.push_back('{'{orrl_pkg::OP_BYTE, 8'h00, 8'h00, 16'd0, 64'd0, 8'h00}, 1'b0,
			'0});
		script.push_back('{'{orrl_pkg::OP_BYTE, 8'hFF, 8'hFF, 16'hFFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 8'hFF}, 1'b0, '0});
		// new begin abandons the rest of the message
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h5A, 8'hA5, 16'd1024,
			64'h0123_4567_89AB_CDEF, 8'h00}, 1'b1, '{12'd1056, 12'd0, 9'd0, 1'b0}});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h01, 8'h80, 16'd1025,
			64'h8000_0000_0000_0001, 8'h00}, 1'b1, '{12'd2096, 12'd0, 9'd0, 1'b0}});
		// first wrap: tail at top is advanced, then one more record evicted
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h10, 8'h20, 16'd1024, 64'd7, 8'h00},
			1'b1, '{12'd0, 12'd1056, 9'd2, 1'b1}});
		for (int i = 0; i < 5; i++)
			script.push_back('{'{orrl_pkg::OP_BYTE, 8'h00, 8'h00, 16'd0, 64'd0,
				8'(1 << i)}, 1'b0, '0});
		// records of assorted lengths, checked by the model
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h33, 8'h44, 16'd1, 64'd1, 8'h00}, 1'b0,
			'0});
		script.push_back('{'{orrl_pkg::OP_BYTE, 8'h00, 8'h00, 16'd0, 64'd0, 8'h7F}, 1'b0,
			'0});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h00, 8'h01, 16'd7, 64'd2, 8'h00}, 1'b0,
			'0});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h02, 8'h03, 16'd8, 64'd3, 8'h00}, 1'b0,
			'0});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h04, 8'h05, 16'd9, 64'd4, 8'h00}, 1'b0,
			'0});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h06, 8'h07, 16'd1023, 64'd5, 8'h00},
			1'b0, '0});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h08, 8'h09, 16'd1000, 64'd6, 8'h00},
			1'b0, '0});
		script.push_back('{'{orrl_pkg::OP_BEGIN, 8'h0A, 8'h0B, 16'd1024, 64'd8, 8'h00},
			1'b0, '0});

		foreach (script[i]) begin
			row       = script[i];
			pin_valid = row.pinned;
			pin_res   = row.want;
			send_request(row.r);
		end
		pin_valid   = 1'b0;
		in_ch.valid = 1'b0;
		drain(40);

		// random phases: none, sender idle, receiver stall, both
		budget = begins_sent + bytes_sent;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 74 : (ph == 3) ? 20 : 0;
			recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 20 : 0;
			if (ph == 0) begin
				// long receiver hold-off while records keep coming
				hold_request = 1'b1;
				repeat (6) send_record();
			end
			while (begins_sent + bytes_sent < budget + 350 * (ph + 1))
				send_record();
			// stretch of no idling inside the phase
			send_idle_pct  = 0;
			recv_stall_pct = 0;
			repeat (3) send_record();
		end
		in_ch.valid = 1'b0;
		drain(40);

		$display("covered %0d begin and %0d byte requests, %0d results checked",
			begins_sent, bytes_sent, results_seen);
		$display("%0d results wrapped the ring, largest eviction count %0d",
			wraps_seen, max_evicted);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("missing results: %0d, mismatches: %0d",
				pending_results.size(), mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#40ms;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
rtl/orrl_pkg.sv
rtl/orrl_if.sv
rtl/orrl_front.sv
rtl/orrl_back.sv
rtl/overwriting_record_ring_log_core.sv
tb/sv/overwriting_record_ring_log_core_tb.sv
